/* hdl/led_grid_message_decoder_core_assert.svh */
// assertion macros shared by the decoder rtl
`ifndef LED_GRID_MESSAGE_DECODER_CORE_ASSERT_SVH
`define LED_GRID_MESSAGE_DECODER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define LGMD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define LGMD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/lgmd_pkg.sv */
// ----------------------------------------------------------------------------
// lgmd_pkg
// Shared constants and types of the led grid message decoder.
// ----------------------------------------------------------------------------
package lgmd_pkg;

  localparam int unsigned MsgBytesDef = 64;
  localparam int unsigned MaxResults  = 32;

  // header codes
  localparam logic [7:0] HdrMask    = 8'hF0;
  localparam logic [7:0] HdrRow     = 8'h70;
  localparam logic [7:0] HdrQLevel  = 8'h1A;
  localparam logic [7:0] HdrQOnOff  = 8'h80;
  localparam logic [7:0] HdrRing    = 8'h92;

  // minimum message lengths
  localparam int unsigned LenRow    = 2;
  localparam int unsigned LenQLevel = 35;
  localparam int unsigned LenQOnOff = 9;
  localparam int unsigned LenRing   = 34;

  localparam logic [3:0] LevelFull  = 4'd15;
  localparam logic [3:0] NibbleMask = 4'h0F;

  // update kinds on the result channel
  localparam logic [1:0] UpdRow  = 2'd0;
  localparam logic [1:0] UpdQuad = 2'd1;
  localparam logic [1:0] UpdRing = 2'd2;

  typedef enum logic [1:0] {
    MODE_ROW    = 2'd0,
    MODE_QLEVEL = 2'd1,
    MODE_QONOFF = 2'd2,
    MODE_RING   = 2'd3
  } mode_e;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_START = 5'b00010,
    S_RD    = 5'b00100,
    S_ROWH  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

endpackage

/* hdl/lgmd_ram.sv */
// ----------------------------------------------------------------------------
// lgmd_ram
// Generic single-write, single-read ram with registered read data.
// ----------------------------------------------------------------------------
module lgmd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/led_grid_message_decoder_core.sv */
// ----------------------------------------------------------------------------
// led_grid_message_decoder_core
// Buffers one serial message in a ram and decodes it into led updates.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one message byte per
//   request, with end_of_message_i high on the final byte. Bytes are taken
//   one per cycle while the decoder is idle; bytes past MSG_BYTES are dropped.
//   After the final byte, if grid_attached is set, the decoder checks the
//   header and length in a setup step, then walks the message ram: a ram
//   read and an emit per quadrant or ring result, and a bits read, a next
//   header read and an emit per row result.
//   in_stall_o stays high during decode.
//   Result channel (out_valid_o / out_stall_i) has an output register; a
//   stalled receiver holds the result and freezes the walk until taken.
//   last_of_run_o marks the final result of a message.
//   cfg_we_i writes grid_attached from cfg_wdata_i; write only while idle.
//   Reset (rst_ni low) empties the byte count, clears grid_attached and
//   drops any pending result. Ram contents are not cleared.
// ----------------------------------------------------------------------------
module led_grid_message_decoder_core #(
  parameter int unsigned MSG_BYTES = lgmd_pkg::MsgBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] msg_byte_i,
  input  logic       end_of_message_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] update_kind_o,
  output logic [7:0] x_pos_o,
  output logic [7:0] y_pos_o,
  output logic [7:0] ring_number_o,
  output logic [7:0] row_bits_o,
  output logic [5:0] led_index_o,
  output logic [3:0] level_first_o,
  output logic [3:0] level_second_o,
  output logic       last_of_run_o
);

  import lgmd_pkg::*;

  `include "led_grid_message_decoder_core_assert.svh"

  localparam int unsigned AW = $clog2(MSG_BYTES);
  localparam int unsigned CW = $clog2(MSG_BYTES + 1);
  localparam int unsigned EW = (CW > 7) ? CW + 1 : 8;
  localparam logic [4:0]  LastIdx = 5'(MaxResults - 1);

  state_e        state_q, state_d;
  mode_e         mode_q, mode_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] n_q, n_d;
  logic          grid_q;
  logic [4:0]    idx_q, idx_d;
  logic [7:0]    hdr_q, hdr_d;
  logic [7:0]    bits_q, bits_d;
  logic          more_q, more_d;
  logic [7:0]    b0_q, b1_q, b2_q;

  logic          in_accept, out_accept, out_load, space;
  logic          ram_we, ram_re;
  logic [7:0]    raddr_full;
  logic [7:0]    rdata;
  logic          res_last;
  logic [7:0]    onoff_sh;
  logic [EW-1:0] n_ext, pos4_ext;

  logic          out_valid_q;
  logic [1:0]    kind_q;
  logic [7:0]    x_q, y_q, ring_q, rbits_q;
  logic [5:0]    lidx_q;
  logic [3:0]    l1_q, l2_q;
  logic          last_q;
  logic [1:0]    kind_d;
  logic [7:0]    x_d, y_d, ring_d, rbits_d;
  logic [3:0]    l1_d, l2_d;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_accept = out_valid_q && !out_stall_i;
  assign space      = !out_valid_q || !out_stall_i;
  assign ram_we     = in_accept && (count_q < CW'(MSG_BYTES));

  lgmd_ram #(
    .Width (8),
    .Depth (MSG_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (msg_byte_i),
    .re_i    (ram_re),
    .raddr_i (raddr_full[AW-1:0]),
    .rdata_o (rdata)
  );

  // room for another row pair: at least four bytes left from this pair
  assign n_ext    = EW'(n_q);
  assign pos4_ext = EW'({idx_q, 1'b0}) + EW'(4);
  assign onoff_sh = rdata >> {idx_q[1:0], 1'b0};

  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    count_d    = count_q;
    n_d        = n_q;
    idx_d      = idx_q;
    hdr_d      = hdr_q;
    bits_d     = bits_q;
    more_d     = more_q;
    ram_re     = 1'b0;
    raddr_full = 8'd0;
    out_load   = 1'b0;
    res_last   = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          n_d     = ram_we ? count_q + CW'(1) : count_q;
          count_d = ram_we ? count_q + CW'(1) : count_q;
          if (end_of_message_i) begin
            count_d = '0;
            if (grid_q) begin
              state_d = S_START;
            end
          end
        end
      end
      S_START: begin
        idx_d   = '0;
        hdr_d   = b0_q;
        state_d = S_RD;
        if ((b0_q & HdrMask) == HdrRow && n_q >= CW'(LenRow)) begin
          mode_d = MODE_ROW;
        end else if (b0_q == HdrQLevel && n_q >= CW'(LenQLevel)) begin
          mode_d = MODE_QLEVEL;
        end else if ((b0_q & HdrMask) == HdrQOnOff && n_q >= CW'(LenQOnOff)) begin
          mode_d = MODE_QONOFF;
        end else if (b0_q == HdrRing && n_q >= CW'(LenRing)) begin
          mode_d = MODE_RING;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        ram_re = 1'b1;
        case (mode_q)
          MODE_ROW:    raddr_full = {2'b00, idx_q, 1'b1};
          MODE_QLEVEL: raddr_full = {3'b000, idx_q} + 8'd3;
          MODE_QONOFF: raddr_full = {5'b00000, idx_q[4:2]} + 8'd1;
          default:     raddr_full = {3'b000, idx_q} + 8'd2;
        endcase
        state_d = (mode_q == MODE_ROW) ? S_ROWH : S_EMIT;
      end
      S_ROWH: begin
        bits_d = rdata;
        more_d = (n_ext >= pos4_ext) && (idx_q != LastIdx);
        if (more_d) begin
          ram_re     = 1'b1;
          raddr_full = {2'b00, idx_q, 1'b0} + 8'd2;
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (mode_q == MODE_ROW) begin
          res_last = !(more_q && ((rdata & HdrMask) == HdrRow));
        end else begin
          res_last = (idx_q == LastIdx);
        end
        if (space) begin
          out_load = 1'b1;
          if (res_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q + 5'd1;
            hdr_d   = rdata;
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // result fields per message kind
  always_comb begin
    kind_d  = UpdQuad;
    x_d     = 8'd0;
    y_d     = 8'd0;
    ring_d  = 8'd0;
    rbits_d = 8'd0;
    l1_d    = rdata[7:4];
    l2_d    = rdata[3:0] & NibbleMask;
    case (mode_q)
      MODE_ROW: begin
        kind_d  = UpdRow;
        y_d     = {4'd0, hdr_q[3:0] & NibbleMask};
        rbits_d = bits_q;
        l1_d    = 4'd0;
        l2_d    = 4'd0;
      end
      MODE_QLEVEL: begin
        x_d = b1_q;
        y_d = b2_q;
      end
      MODE_QONOFF: begin
        x_d  = {4'd0, b0_q[0], 3'd0};
        y_d  = {4'd0, b0_q[1], 3'd0};
        l1_d = onoff_sh[0] ? LevelFull : 4'd0;
        l2_d = onoff_sh[1] ? LevelFull : 4'd0;
      end
      default: begin
        kind_d = UpdRing;
        ring_d = b1_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      grid_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (cfg_we_i) begin
        grid_q <= cfg_wdata_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_accept) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    n_q    <= n_d;
    idx_q  <= idx_d;
    hdr_q  <= hdr_d;
    bits_q <= bits_d;
    more_q <= more_d;
    // header and first two payload bytes kept in flops
    if (ram_we && count_q == CW'(0)) begin
      b0_q <= msg_byte_i;
    end
    if (ram_we && count_q == CW'(1)) begin
      b1_q <= msg_byte_i;
    end
    if (ram_we && count_q == CW'(2)) begin
      b2_q <= msg_byte_i;
    end
    if (out_load) begin
      kind_q  <= kind_d;
      x_q     <= x_d;
      y_q     <= y_d;
      ring_q  <= ring_d;
      rbits_q <= rbits_d;
      lidx_q  <= (mode_q == MODE_ROW) ? 6'd0 : {idx_q, 1'b0};
      l1_q    <= l1_d;
      l2_q    <= l2_d;
      last_q  <= res_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign update_kind_o  = kind_q;
  assign x_pos_o        = x_q;
  assign y_pos_o        = y_q;
  assign ring_number_o  = ring_q;
  assign row_bits_o     = rbits_q;
  assign led_index_o    = lidx_q;
  assign level_first_o  = l1_q;
  assign level_second_o = l2_q;
  assign last_of_run_o  = last_q;

  `LGMD_ASSERT_NOW(a_count_bound, clk_i, rst_ni, 1'b1, count_q <= CW'(MSG_BYTES),
    "byte count above buffer size")
  `LGMD_ASSERT_NOW(a_count_clear_busy, clk_i, rst_ni, state_q != S_IDLE, count_q == '0,
    "byte count not empty during decode")
  `LGMD_ASSERT_NEXT(a_eom_clears, clk_i, rst_ni, in_accept && end_of_message_i,
    count_q == '0, "end of message did not empty the byte count")
  `LGMD_ASSERT_NEXT(a_last_idle, clk_i, rst_ni, out_load && res_last,
    state_q == S_IDLE && last_of_run_o, "decoder busy after last result")

endmodule
